// ----- sv/fapt_pkg.sv -----
// Shared types and constants for the all-bases Fermat primality test unit.
// Used by the top level and by the modular multiplier; no dependencies.
package fapt_pkg;

   // Width of the candidate field on the request channel.
   localparam int CANDIDATE_WIDTH = 16;

   // Sequencer states of the test unit.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_POW,
      ST_MUL_ACC,
      ST_MUL_SQ,
      ST_FINISH
   } fapt_state_type;

   // Control from the sequencer to the modular multiplier.
   typedef struct packed {
      logic start;
      logic use_acc;
   } fapt_mul_ctl_type;

   // Status from the modular multiplier back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } fapt_mul_sts_type;

endpackage

// ----- sv/fapt_modmul.sv -----
// Bit-serial modular multiplier: result = (a * b) mod m, one multiplier bit a cycle.
// Depends on fapt_pkg for the control and status structs.
module fapt_modmul #(
   parameter int NUMBER_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fapt_pkg::fapt_mul_ctl_type    mul_ctl,
   input  logic [NUMBER_WIDTH-1:0]       op_a,
   input  logic [NUMBER_WIDTH-1:0]       op_b,
   input  logic [NUMBER_WIDTH-1:0]       op_m,
   output fapt_pkg::fapt_mul_sts_type    mul_sts,
   output logic [NUMBER_WIDTH-1:0]       result
);
   import fapt_pkg::*;

   localparam int CW = $clog2(NUMBER_WIDTH);
   localparam int TW = NUMBER_WIDTH + 2;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [NUMBER_WIDTH-1:0] a_ff, a_in;
   logic [NUMBER_WIDTH-1:0] b_ff, b_in;
   logic [NUMBER_WIDTH-1:0] m_ff, m_in;
   logic [NUMBER_WIDTH-1:0] acc_ff, acc_in;

   logic [TW-1:0]           sum;
   logic [NUMBER_WIDTH-1:0] sub_one;
   logic [NUMBER_WIDTH-1:0] sub_two;
   logic [TW-1:0]           m_one;
   logic [TW-1:0]           m_two;

   // One step: double the accumulator, add a when the top bit of b is set,
   // then reduce the sum (below three times m) by m or by twice m.
   always_comb begin
      m_one   = {2'b00, m_ff};
      m_two   = {1'b0, m_ff, 1'b0};
      sum     = {1'b0, acc_ff, 1'b0} + (b_ff[NUMBER_WIDTH-1] ? {2'b00, a_ff} : '0);
      sub_one = NUMBER_WIDTH'(sum - m_one);
      sub_two = NUMBER_WIDTH'(sum - m_two);
   end

   // Next values of the multiplier registers. The multiplicand is op_a when
   // use_acc is set and op_b otherwise, so op_b alone gives a squaring.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      m_in     = m_ff;
      acc_in   = acc_ff;
      if (mul_ctl.start) begin
         busy_in  = 1'b1;
         count_in = CW'(NUMBER_WIDTH - 1);
         a_in     = mul_ctl.use_acc ? op_a : op_b;
         b_in     = op_b;
         m_in     = op_m;
         acc_in   = '0;
      end else if (busy_ff) begin
         if (sum >= m_two) begin
            acc_in = sub_two;
         end else if (sum >= m_one) begin
            acc_in = sub_one;
         end else begin
            acc_in = sum[NUMBER_WIDTH-1:0];
         end
         b_in = {b_ff[NUMBER_WIDTH-2:0], 1'b0};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   // Control registers take reset; operands do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      m_ff     <= m_in;
      acc_ff   <= acc_in;
   end

   assign mul_sts.busy = busy_ff;
   assign mul_sts.done = done_ff;
   assign result       = acc_ff;

endmodule

// ----- sv/fermat_all_bases_primality_test_unit.sv -----
// Top level of the all-bases Fermat primality test unit.
// Depends on fapt_pkg and on fapt_modmul, the shared modular multiplier.
//
// Tests one unsigned candidate n at a time and answers whether it is prime by
// trying every base b from 2 to n-1: each base must have gcd(b, n) = 1 and
// b^(n-1) mod n = 1, and the first base that fails ends the test with not
// prime. Zero and one give not prime, two gives prime. The candidate is cut or
// zero-extended to NUMBER_WIDTH bits. The request side stalls from acceptance
// until the answer has moved into the response register, so one item is in
// work at a time; the next item may be taken while an answer waits. An item
// with n below 3 goes straight to the finish state; otherwise, per base tried,
// a subtractive gcd runs and then the modular power takes, for each bit of n-1,
// a sequencer step and one squaring plus one multiply when the bit is set, on
// the single bit-serial multiplier.
module fermat_all_bases_primality_test_unit #(
   parameter int NUMBER_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [fapt_pkg::CANDIDATE_WIDTH-1:0] req_candidate,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_is_prime
);
   import fapt_pkg::*;

   localparam int NW = NUMBER_WIDTH;

   fapt_state_type state_ff, state_in;

   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] base_ff, base_in;
   logic [NW-1:0] left_ff, left_in;
   logic [NW-1:0] right_ff, right_in;
   logic [NW-1:0] acc_ff, acc_in;
   logic [NW-1:0] sq_ff, sq_in;
   logic [NW-1:0] exp_ff, exp_in;
   logic          prime_ff, prime_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_is_prime_ff, rsp_is_prime_in;

   logic [NW-1:0]                 cand_mask;
   logic [NW:0]                   gcd_diff;
   logic                          gcd_borrow;
   logic [NW-1:0]                 base_next;
   logic                          accept;
   logic                          load_rsp;
   fapt_mul_ctl_type              mul_ctl;
   fapt_mul_sts_type              mul_sts;
   logic [NW-1:0]                 mul_result;

   // Candidate reduced to the working width.
   assign cand_mask = NW'(req_candidate);

   // Shared subtractor of the gcd, and the following base.
   assign gcd_diff   = {1'b0, left_ff} - {1'b0, right_ff};
   assign gcd_borrow = gcd_diff[NW];
   assign base_next  = base_ff + NW'(1);

   assign accept = req_valid && !req_stall;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (cand_mask < NW'(3)) ? ST_FINISH : ST_GCD;
            end
         end
         ST_GCD: begin
            if (right_ff == '0) begin
               state_in = (left_ff == NW'(1)) ? ST_POW : ST_FINISH;
            end
         end
         ST_POW: begin
            if (exp_ff == '0) begin
               if (acc_ff != NW'(1) || base_next == n_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_GCD;
               end
            end else if (exp_ff[0]) begin
               state_in = ST_MUL_ACC;
            end else begin
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_ACC: begin
            if (mul_sts.done) begin
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            if (mul_sts.done) begin
               state_in = ST_POW;
            end
         end
         ST_FINISH: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: handshake and multiplier control.
   always_comb begin
      req_stall       = 1'b1;
      load_rsp        = 1'b0;
      mul_ctl.start   = 1'b0;
      mul_ctl.use_acc = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_POW: begin
            if (exp_ff != '0) begin
               mul_ctl.start   = 1'b1;
               mul_ctl.use_acc = exp_ff[0];
            end
         end
         ST_MUL_ACC: begin
            mul_ctl.start = mul_sts.done;
         end
         ST_FINISH: begin
            load_rsp = !(rsp_valid_ff && rsp_stall);
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      n_in     = n_ff;
      base_in  = base_ff;
      left_in  = left_ff;
      right_in = right_ff;
      acc_in   = acc_ff;
      sq_in    = sq_ff;
      exp_in   = exp_ff;
      prime_in = prime_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in     = cand_mask;
               base_in  = NW'(2);
               left_in  = NW'(2);
               right_in = cand_mask;
               prime_in = (cand_mask == NW'(2));
            end
         end
         ST_GCD: begin
            if (right_ff == '0) begin
               if (left_ff == NW'(1)) begin
                  acc_in = NW'(1);
                  sq_in  = base_ff;
                  exp_in = n_ff - NW'(1);
               end else begin
                  prime_in = 1'b0;
               end
            end else if (!gcd_borrow) begin
               left_in = gcd_diff[NW-1:0];
            end else begin
               left_in  = right_ff;
               right_in = left_ff;
            end
         end
         ST_POW: begin
            if (exp_ff == '0) begin
               if (acc_ff == NW'(1)) begin
                  base_in  = base_next;
                  left_in  = base_next;
                  right_in = n_ff;
                  prime_in = (base_next == n_ff);
               end else begin
                  prime_in = 1'b0;
               end
            end
         end
         ST_MUL_ACC: begin
            if (mul_sts.done) begin
               acc_in = mul_result;
            end
         end
         ST_MUL_SQ: begin
            if (mul_sts.done) begin
               sq_in  = mul_result;
               exp_in = {1'b0, exp_ff[NW-1:1]};
            end
         end
         default: begin
            n_in = n_ff;
         end
      endcase
   end

   // Response register: holds an answer until the receiver takes it.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_is_prime_in = rsp_is_prime_ff;
      if (load_rsp) begin
         rsp_valid_in    = 1'b1;
         rsp_is_prime_in = prime_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Registers: control state takes reset, payload does not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff            <= n_in;
      base_ff         <= base_in;
      left_ff         <= left_in;
      right_ff        <= right_in;
      acc_ff          <= acc_in;
      sq_ff           <= sq_in;
      exp_ff          <= exp_in;
      prime_ff        <= prime_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   // Shared modular multiplier for both the multiply and the squaring.
   fapt_modmul #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .mul_ctl (mul_ctl),
      .op_a    (acc_ff),
      .op_b    (sq_ff),
      .op_m    (n_ff),
      .mul_sts (mul_sts),
      .result  (mul_result)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

`ifndef ASSERT_OFF
   // The multiplier only finishes while the sequencer waits for it.
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> (state_ff == ST_MUL_ACC || state_ff == ST_MUL_SQ))
      else $error("multiplier finished outside a wait state");

   // A started multiply never overlaps one that is still running.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      mul_ctl.start |-> !mul_sts.busy)
      else $error("multiply started while the multiplier is busy");

   // The base under test stays between two and n-1.
   a_base_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD) |-> (base_ff >= NW'(2) && base_ff < n_ff))
      else $error("base out of range during gcd");

   // Power operands stay reduced modulo n.
   a_pow_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POW) |-> (acc_ff < n_ff && sq_ff < n_ff))
      else $error("power operands not reduced");

   // A prime answer never comes from a candidate below two.
   a_prime_sane: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && prime_ff) |=> (rsp_valid && rsp_is_prime && n_ff >= NW'(2)))
      else $error("prime reported for a candidate below two");
`endif

endmodule
